>>> hdl/ssr_pkg.sv
package ssr_pkg;

    // stack capacity and derived widths
    localparam int MAX_LEN = 32;
    localparam int VAL_W   = 6;
    localparam int LEN_W   = 6;
    localparam int DEPTH_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int NUM_W   = $clog2(MAX_LEN + 2);
    localparam int CNT_W   = LEN_W;

    // result codes
    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_FAIL = 2'd2
    } op_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic failed;
        logic slot_free;
        logic stack_empty;
        op_t  step_op;
    } stat_t;

endpackage

>>> hdl/ssr_ctrl.sv
module ssr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ssr_pkg::stat_t stat,
    output ssr_pkg::cmd_t  cmd
);
    import ssr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !stat.failed)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (stat.slot_free && (stat.step_op inside {OP_POP, OP_FAIL}))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.step   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_RUN:
            begin
                cmd.step = stat.slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> hdl/ssr_dpath.sv
module ssr_dpath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ssr_pkg::LEN_W-1:0]  cfg_data,
    input  logic [ssr_pkg::VAL_W-1:0]  target_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 stack_op,
    output logic [ssr_pkg::VAL_W-1:0]  op_value,
    output logic                       run_last,
    input  ssr_pkg::cmd_t              cmd,
    output ssr_pkg::stat_t             stat
);
    import ssr_pkg::*;

    // configuration and run state
    logic [LEN_W-1:0]   seq_len_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [NUM_W-1:0]   number_reg;
    logic [CNT_W-1:0]   items_reg;
    logic               failed_reg;
    logic               last_reg;
    logic [VAL_W-1:0]   target_reg;
    logic [VAL_W-1:0]   top_reg;
    logic [VAL_W-1:0]   stack_store_reg [MAX_LEN];

    // output register
    logic               out_valid_reg;
    op_t                op_reg;
    logic [VAL_W-1:0]   value_reg;
    logic               last_out_reg;

    logic [LEN_W-1:0]   eff_len;
    logic               is_last;
    logic [VAL_W-1:0]   top_value;
    logic               has_top;
    op_t                step_op;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   wr_idx;

    assign cfg_ready = 1'b1;

    // effective length: zero acts as one, clipped to capacity
    always_comb
    begin
        eff_len = seq_len_reg;
        if (seq_len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (seq_len_reg > LEN_W'(MAX_LEN))
        begin
            eff_len = LEN_W'(MAX_LEN);
        end
    end

    // last item of the run
    assign is_last = ({1'b0, items_reg} + (CNT_W + 1)'(1)) >= {1'b0, eff_len};

    // top of stack is held in a register, the entry below it is fetched on a pop
    assign has_top   = (depth_reg != '0);
    assign rd_idx    = IDX_W'(depth_reg - DEPTH_W'(2));
    assign wr_idx    = IDX_W'(depth_reg);
    assign top_value = top_reg;

    // decide the next stack operation
    always_comb
    begin
        if (has_top && (top_value == target_reg))
        begin
            step_op = OP_POP;
        end
        else if (has_top && (top_value > target_reg))
        begin
            step_op = OP_FAIL;
        end
        else if ((number_reg > NUM_W'(eff_len)) || (depth_reg >= DEPTH_W'(MAX_LEN)))
        begin
            step_op = OP_FAIL;
        end
        else
        begin
            step_op = OP_PUSH;
        end
    end

    assign stat.failed      = failed_reg;
    assign stat.slot_free   = !out_valid_reg || out_ready;
    assign stat.stack_empty = !has_top;
    assign stat.step_op     = step_op;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= LEN_W'(32);
        end
        else if (cfg_valid)
        begin
            seq_len_reg <= cfg_data;
        end
    end

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= '0;
            number_reg <= NUM_W'(1);
            items_reg  <= '0;
            failed_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else if (cmd.accept)
        begin
            last_reg  <= is_last;
            items_reg <= is_last ? '0 : items_reg + CNT_W'(1);
            if (failed_reg && is_last)
            begin
                depth_reg  <= '0;
                number_reg <= NUM_W'(1);
                failed_reg <= 1'b0;
            end
        end
        else if (cmd.step)
        begin
            case (step_op)
                OP_PUSH:
                begin
                    depth_reg  <= depth_reg + DEPTH_W'(1);
                    number_reg <= number_reg + NUM_W'(1);
                end
                OP_POP:
                begin
                    if (last_reg)
                    begin
                        depth_reg  <= '0;
                        number_reg <= NUM_W'(1);
                    end
                    else
                    begin
                        depth_reg <= depth_reg - DEPTH_W'(1);
                    end
                end
                default:
                begin
                    if (last_reg)
                    begin
                        depth_reg  <= '0;
                        number_reg <= NUM_W'(1);
                    end
                    else
                    begin
                        failed_reg <= 1'b1;
                    end
                end
            endcase
        end
    end

    // target latch, stack storage and top of stack
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            target_reg <= target_value;
        end
        if (cmd.step && (step_op == OP_PUSH))
        begin
            stack_store_reg[wr_idx] <= VAL_W'(number_reg);
            top_reg                 <= VAL_W'(number_reg);
        end
        else if (cmd.step && (step_op == OP_POP) && (depth_reg > DEPTH_W'(1)))
        begin
            top_reg <= stack_store_reg[rd_idx];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            op_reg <= step_op;
            case (step_op)
                OP_PUSH:
                begin
                    value_reg    <= VAL_W'(number_reg);
                    last_out_reg <= 1'b0;
                end
                OP_POP:
                begin
                    value_reg    <= top_value;
                    last_out_reg <= last_reg;
                end
                default:
                begin
                    value_reg    <= '0;
                    last_out_reg <= last_reg;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign stack_op  = op_reg;
    assign op_value  = value_reg;
    assign run_last  = last_out_reg;

endmodule

>>> hdl/stack_sequence_realizer.sv
// first result: an accepted request starts a run, whose steps are registered
// throughput: one stack operation per cycle while the result slot is free;
// an item is its pushes and one pop or fail step, then idle takes the next
// items after a failure are accepted in idle and give no result
// reset: asynchronous active low; empty stack, next number 1, length 32
module stack_sequence_realizer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ssr_pkg::LEN_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ssr_pkg::VAL_W-1:0]  target_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 stack_op,
    output logic [ssr_pkg::VAL_W-1:0]  op_value,
    output logic                       run_last
);
    import ssr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    ssr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stack, counters and result register
    ssr_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .target_value (target_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .stack_op     (stack_op),
        .op_value     (op_value),
        .run_last     (run_last),
        .cmd          (cmd),
        .stat         (stat)
    );

`ifndef SYNTHESIS
    // a live request always moves the sequencer out of idle
    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !stat.failed) |=> !in_ready)
        else $error("live request did not start a run");

    // a pop never happens on an empty stack
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && (stat.step_op == OP_POP)) |-> !stat.stack_empty)
        else $error("pop issued on empty stack");

    // a step only fires when the result register can take it
    a_step_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !cmd.step)
        else $error("step overwrote a pending result");
`endif

endmodule
